FILE: design/dtmf_pkg.sv
// Shared constants, types and constant tables of the DTMF tone generator.
package dtmf_pkg;

   localparam int SAMPLE_RATE      = 44100;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int PHASE_BITS       = 32;

   localparam int IDX_BITS  = $clog2(SINE_TABLE_DEPTH);
   localparam int QTR       = SINE_TABLE_DEPTH / 4;
   localparam int QTR_BITS  = IDX_BITS - 2;
   localparam int ADDR_BITS = QTR_BITS + 1;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam int AMP_BITS       = 14;
   localparam int LEN_BITS       = 20;
   localparam int FADE_BITS      = 16;
   localparam int KEY_BITS       = 4;
   localparam int SAMPLE_BITS    = 16;
   localparam int ROM_BITS       = 16;
   localparam int SUM_BITS       = 17;
   localparam int PROD_BITS      = 32;
   localparam int CSR_DATA_BITS  = 20;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [AMP_BITS-1:0]  AMPLITUDE_RESET    = AMP_BITS'(8000);
   localparam logic [LEN_BITS-1:0]  TONE_SAMPLES_RESET = LEN_BITS'(22050);
   localparam logic [FADE_BITS-1:0] FADE_SAMPLES_RESET = FADE_BITS'(100);

   localparam int QUEUE_DEPTH  = 2;
   localparam int DIV_STEPS    = 16;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_AMPLITUDE    = 2'd0,
      CSR_TONE_SAMPLES = 2'd1,
      CSR_FADE_SAMPLES = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_READ_LO,
      BK_READ_HI,
      BK_SUM,
      BK_AMP,
      BK_SAT,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } back_state_type;

   // One classified tick, handed from the front to the back.
   typedef struct packed {
      logic                  active;
      logic                  last;
      logic                  fade_in;
      logic                  fade_out;
      logic [ADDR_BITS-1:0]  lo_addr;
      logic                  lo_neg;
      logic [ADDR_BITS-1:0]  hi_addr;
      logic                  hi_neg;
      logic [AMP_BITS-1:0]   amplitude;
      logic [FADE_BITS-1:0]  n_in;
      logic [FADE_BITS-1:0]  n_out;
      logic [FADE_BITS-1:0]  f_len;
   } job_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   active;
      logic                   last;
   } rsp_type;

   typedef logic [ROM_BITS-1:0]   qtab_type [0:QTR];
   typedef logic [PHASE_BITS-1:0] step_rom_type [0:7];

   // Quarter-wave sine in Q1.15, from an eight-term Taylor series in Q2.30.
   function automatic qtab_type build_qtab();
      qtab_type    tab;
      logic [63:0] t;
      logic [63:0] term;
      logic [63:0] sum;
      int          k;
      for (int m = 0; m <= QTR; m++) begin
         t    = (64'(m) * HALF_PI_Q30) / QTR;
         term = t;
         sum  = t;
         for (k = 1; k < 8; k++) begin
            term = (term * t) >> 30;
            term = (term * t) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) != 0) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         sum    = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
         tab[m] = (sum > 64'd32767) ? ROM_BITS'(32767) : sum[ROM_BITS-1:0];
      end
      return tab;
   endfunction

   // Phase increments: rows first, then columns.
   function automatic step_rom_type build_step_rom();
      step_rom_type tab;
      logic [63:0]  freq;
      for (int k = 0; k < 8; k++) begin
         unique case (k)
            0: freq = 64'd697;
            1: freq = 64'd770;
            2: freq = 64'd852;
            3: freq = 64'd941;
            4: freq = 64'd1209;
            5: freq = 64'd1336;
            6: freq = 64'd1477;
            default: freq = 64'd1633;
         endcase
         tab[k] = PHASE_BITS'(((freq << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) / SAMPLE_RATE);
      end
      return tab;
   endfunction

endpackage

FILE: design/dtmf_queue.sv
// Small first-in first-out queue of registers used between the stages.
module dtmf_queue #(
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head
);

   localparam int PTR_BITS   = (dtmf_pkg::QUEUE_DEPTH > 1) ? $clog2(dtmf_pkg::QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(dtmf_pkg::QUEUE_DEPTH + 1);

   item_type              entries_ff [dtmf_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (count_ff == COUNT_BITS'(dtmf_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(dtmf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(dtmf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/dtmf_front.sv
// Front end: configuration registers, tone state and classification of each tick.
module dtmf_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  logic                                req_start_req,
   input  logic [dtmf_pkg::KEY_BITS-1:0]       req_key_code,
   input  logic                                csr_write_en,
   input  logic [dtmf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dtmf_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                job_full,
   output logic                                job_push,
   output dtmf_pkg::job_type                   job
);

   localparam dtmf_pkg::step_rom_type STEP_ROM = dtmf_pkg::build_step_rom();
   localparam int PB = dtmf_pkg::PHASE_BITS;
   localparam int LB = dtmf_pkg::LEN_BITS;
   localparam int FB = dtmf_pkg::FADE_BITS;

   logic [dtmf_pkg::AMP_BITS-1:0] amplitude_ff;
   logic [LB-1:0]                 tone_samples_ff;
   logic [FB-1:0]                 fade_samples_ff;

   logic                          playing_ff, playing_in;
   logic [LB-1:0]                 position_ff, position_in;
   logic [dtmf_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [PB-1:0]                 lo_phase_ff, lo_phase_in;
   logic [PB-1:0]                 hi_phase_ff, hi_phase_in;

   logic                          eff_playing;
   logic [LB-1:0]                 eff_pos;
   logic [dtmf_pkg::KEY_BITS-1:0] eff_key;
   logic [PB-1:0]                 eff_lo;
   logic [PB-1:0]                 eff_hi;
   logic [LB-1:0]                 n_len;
   logic [FB-1:0]                 f_len;
   logic                          fin;
   logic [dtmf_pkg::IDX_BITS-1:0] lo_idx;
   logic [dtmf_pkg::IDX_BITS-1:0] hi_idx;
   logic [LB-1:0]                 remain;

   function automatic logic [dtmf_pkg::ADDR_BITS-1:0] fold_addr(
      input logic [dtmf_pkg::IDX_BITS-1:0] idx
   );
      logic [dtmf_pkg::ADDR_BITS-1:0] r;
      r = {1'b0, idx[dtmf_pkg::QTR_BITS-1:0]};
      return idx[dtmf_pkg::QTR_BITS] ? dtmf_pkg::ADDR_BITS'(dtmf_pkg::QTR) - r : r;
   endfunction

   assign job_push = req_push && !job_full;

   always_comb begin
      eff_playing = req_start_req || playing_ff;
      eff_pos     = req_start_req ? '0 : position_ff;
      eff_key     = req_start_req ? req_key_code : key_ff;
      eff_lo      = req_start_req ? '0 : lo_phase_ff;
      eff_hi      = req_start_req ? '0 : hi_phase_ff;

      n_len  = (tone_samples_ff == '0) ? LB'(1) : tone_samples_ff;
      f_len  = ({{(LB - FB){1'b0}}, fade_samples_ff} < n_len) ? fade_samples_ff
                                                             : n_len[FB-1:0];
      fin    = ((LB + 1)'(eff_pos) + (LB + 1)'(1)) >= (LB + 1)'(n_len);
      remain = (eff_pos < n_len) ? n_len - eff_pos : '0;
      lo_idx = eff_lo[PB-1 -: dtmf_pkg::IDX_BITS];
      hi_idx = eff_hi[PB-1 -: dtmf_pkg::IDX_BITS];

      job.active    = eff_playing;
      job.last      = eff_playing && fin;
      job.fade_in   = eff_playing && (f_len != '0) && (eff_pos < LB'(f_len));
      job.fade_out  = eff_playing && (f_len != '0)
                      && (((LB + 1)'(eff_pos) + (LB + 1)'(f_len)) >= (LB + 1)'(n_len));
      job.lo_addr   = fold_addr(lo_idx);
      job.lo_neg    = lo_idx[dtmf_pkg::IDX_BITS-1];
      job.hi_addr   = fold_addr(hi_idx);
      job.hi_neg    = hi_idx[dtmf_pkg::IDX_BITS-1];
      job.amplitude = amplitude_ff;
      job.n_in      = eff_pos[FB-1:0];
      // The fade-out factor never exceeds the fade length when the fade-out applies.
      job.n_out     = remain[FB-1:0];
      job.f_len     = f_len;

      playing_in  = eff_playing;
      position_in = eff_pos;
      key_in      = eff_key;
      lo_phase_in = eff_lo;
      hi_phase_in = eff_hi;
      if (eff_playing) begin
         if (fin) begin
            playing_in  = 1'b0;
            position_in = '0;
         end else begin
            position_in = eff_pos + 1'b1;
            lo_phase_in = eff_lo + STEP_ROM[{1'b0, eff_key[3:2]}];
            hi_phase_in = eff_hi + STEP_ROM[{1'b1, eff_key[1:0]}];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff  <= 1'b0;
         position_ff <= '0;
         key_ff      <= '0;
         lo_phase_ff <= '0;
         hi_phase_ff <= '0;
      end else if (job_push) begin
         playing_ff  <= playing_in;
         position_ff <= position_in;
         key_ff      <= key_in;
         lo_phase_ff <= lo_phase_in;
         hi_phase_ff <= hi_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff    <= dtmf_pkg::AMPLITUDE_RESET;
         tone_samples_ff <= dtmf_pkg::TONE_SAMPLES_RESET;
         fade_samples_ff <= dtmf_pkg::FADE_SAMPLES_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            dtmf_pkg::CSR_AMPLITUDE: amplitude_ff <= csr_wdata[dtmf_pkg::AMP_BITS-1:0];
            dtmf_pkg::CSR_TONE_SAMPLES: tone_samples_ff <= csr_wdata[LB-1:0];
            dtmf_pkg::CSR_FADE_SAMPLES: fade_samples_ff <= csr_wdata[FB-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: design/dtmf_back.sv
// Back end: sine lookup, amplitude scaling and the iterative fade divider.
module dtmf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_empty,
   output logic                job_pop,
   input  dtmf_pkg::job_type   job,
   input  logic                res_full,
   output logic                res_push,
   output dtmf_pkg::rsp_type   res
);

   localparam dtmf_pkg::qtab_type QTAB = dtmf_pkg::build_qtab();
   localparam int SB = dtmf_pkg::SUM_BITS;
   localparam int PR = dtmf_pkg::PROD_BITS;
   localparam int FB = dtmf_pkg::FADE_BITS;
   localparam int MB = dtmf_pkg::SAMPLE_BITS;

   dtmf_pkg::back_state_type state_ff, state_in;

   dtmf_pkg::job_type                   job_ff;
   logic [dtmf_pkg::ADDR_BITS-1:0]      rom_addr;
   logic [dtmf_pkg::ROM_BITS-1:0]       rom_data_ff;
   logic signed [SB-1:0]                rom_signed;
   logic signed [SB-1:0]                sum_ff;
   logic signed [PR-1:0]                prod_ff;
   logic [PR-1:0]                       prod_mag;
   logic [PR-1:0]                       prod_shr;
   logic [MB-1:0]                       mag_ff;
   logic                                neg_ff;
   logic                                pass_ff;
   logic [FB-1:0]                       rem_ff;
   logic [FB-1:0]                       quo_ff;
   logic [dtmf_pkg::DIV_CNT_BITS-1:0]   cnt_ff;
   logic [2*FB-1:0]                     dividend;
   logic [FB:0]                         trial;
   logic                                q_bit;
   logic [FB:0]                         rem_next;
   logic                                div_last;

   assign rom_signed = SB'($signed({1'b0, rom_data_ff}));
   assign prod_mag   = prod_ff[PR-1] ? PR'(-prod_ff) : PR'(prod_ff);
   assign prod_shr   = prod_mag >> 15;
   assign dividend   = (2 * FB)'(mag_ff) * (2 * FB)'(pass_ff ? job_ff.n_out : job_ff.n_in);
   assign trial      = {rem_ff, quo_ff[FB-1]};
   assign q_bit      = (trial >= {1'b0, job_ff.f_len});
   assign rem_next   = q_bit ? trial - {1'b0, job_ff.f_len} : trial;
   assign div_last   = (cnt_ff == dtmf_pkg::DIV_CNT_BITS'(dtmf_pkg::DIV_STEPS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dtmf_pkg::BK_IDLE: begin
            if (!job_empty) begin
               state_in = job.active ? dtmf_pkg::BK_READ_LO : dtmf_pkg::BK_DONE;
            end
         end
         dtmf_pkg::BK_READ_LO: state_in = dtmf_pkg::BK_READ_HI;
         dtmf_pkg::BK_READ_HI: state_in = dtmf_pkg::BK_SUM;
         dtmf_pkg::BK_SUM:     state_in = dtmf_pkg::BK_AMP;
         dtmf_pkg::BK_AMP:     state_in = dtmf_pkg::BK_SAT;
         dtmf_pkg::BK_SAT: begin
            state_in = (job_ff.fade_in || job_ff.fade_out) ? dtmf_pkg::BK_MUL
                                                            : dtmf_pkg::BK_DONE;
         end
         dtmf_pkg::BK_MUL: state_in = dtmf_pkg::BK_DIV;
         dtmf_pkg::BK_DIV: begin
            if (div_last) begin
               state_in = (!pass_ff && job_ff.fade_out) ? dtmf_pkg::BK_MUL
                                                         : dtmf_pkg::BK_DONE;
            end
         end
         dtmf_pkg::BK_DONE: begin
            if (!res_full) begin
               state_in = dtmf_pkg::BK_IDLE;
            end
         end
         default: state_in = dtmf_pkg::BK_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      job_pop    = (state_ff == dtmf_pkg::BK_IDLE) && !job_empty;
      res_push   = (state_ff == dtmf_pkg::BK_DONE) && !res_full;
      rom_addr   = (state_ff == dtmf_pkg::BK_READ_LO) ? job_ff.lo_addr : job_ff.hi_addr;
      res.sample = neg_ff ? MB'(-{1'b0, mag_ff}) : mag_ff;
      res.active = job_ff.active;
      res.last   = job_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtmf_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rom_data_ff <= QTAB[rom_addr];
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         dtmf_pkg::BK_IDLE: begin
            if (!job_empty) begin
               job_ff <= job;
               mag_ff <= '0;
               neg_ff <= 1'b0;
            end
         end
         dtmf_pkg::BK_READ_HI: begin
            sum_ff <= job_ff.lo_neg ? -rom_signed : rom_signed;
         end
         dtmf_pkg::BK_SUM: begin
            sum_ff <= sum_ff + (job_ff.hi_neg ? -rom_signed : rom_signed);
         end
         dtmf_pkg::BK_AMP: begin
            prod_ff <= PR'(sum_ff) * PR'($signed({1'b0, job_ff.amplitude}));
         end
         dtmf_pkg::BK_SAT: begin
            // Truncation toward zero, then clamp to the signed 16-bit range.
            neg_ff  <= prod_ff[PR-1];
            pass_ff <= !job_ff.fade_in;
            if (prod_ff[PR-1]) begin
               mag_ff <= (prod_shr > PR'(32768)) ? MB'(32768) : prod_shr[MB-1:0];
            end else begin
               mag_ff <= (prod_shr > PR'(32767)) ? MB'(32767) : prod_shr[MB-1:0];
            end
         end
         dtmf_pkg::BK_MUL: begin
            // The fade factor never exceeds the fade length, so the quotient fits 16 bits.
            rem_ff <= dividend[2*FB-1:FB];
            quo_ff <= dividend[FB-1:0];
            cnt_ff <= '0;
         end
         dtmf_pkg::BK_DIV: begin
            rem_ff <= rem_next[FB-1:0];
            quo_ff <= {quo_ff[FB-2:0], q_bit};
            cnt_ff <= cnt_ff + 1'b1;
            if (div_last) begin
               mag_ff  <= {quo_ff[FB-2:0], q_bit};
               pass_ff <= 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: design/dtmf_tone_generator_with_fade_top.sv
// Top level of the DTMF tone generator with linear fade-in and fade-out.
//
// Input channel (req_): one sample tick per transfer. req_start_req high loads
// req_key_code and restarts the tone; otherwise the tick continues or idles.
// The transfer happens on a clock edge with req_push high and req_full low.
// Result channel (rsp_): one result per tick, in order. rsp_sample, rsp_active
// and rsp_last show the oldest result while rsp_empty is low; rsp_pop takes it.
// Configuration (csr_): amplitude, tone length and fade length, to be written by
// the user only while the block is idle, which the block does not enforce; a
// write is used from the next tick on. The front classifies a tick in its
// transfer cycle and queues it; the back works one tick at a time. An idle tick
// goes straight from idle to done; a tone sample without fade reads the low and
// high tones from the table, sums, scales and saturates, and each fade adds a
// multiply and a run of the one-bit-per-cycle divider. Two-entry queues on both
// sides let the input keep flowing while a result waits; when the receiver
// stalls, the queues fill and req_full rises.
// Synchronous reset empties both queues, stops the tone and restores the
// register reset values.
module dtmf_tone_generator_with_fade_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_start_req,
   input  logic [dtmf_pkg::KEY_BITS-1:0]       req_key_code,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [dtmf_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                rsp_active,
   output logic                                rsp_last,
   input  logic                                csr_write_en,
   input  logic [dtmf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dtmf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   dtmf_pkg::job_type job_in;
   dtmf_pkg::job_type job_head;
   dtmf_pkg::rsp_type res_in;
   dtmf_pkg::rsp_type res_head;
   logic              job_push;
   logic              job_full;
   logic              job_pop;
   logic              job_empty;
   logic              res_push;
   logic              res_full;

   dtmf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_start_req (req_start_req),
      .req_key_code  (req_key_code),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .job_full      (job_full),
      .job_push      (job_push),
      .job           (job_in)
   );

   dtmf_queue #(.item_type(dtmf_pkg::job_type)) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .empty     (job_empty),
      .head      (job_head)
   );

   dtmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .job       (job_head),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res_in)
   );

   dtmf_queue #(.item_type(dtmf_pkg::rsp_type)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (res_head)
   );

   assign req_full   = job_full;
   assign rsp_sample = res_head.sample;
   assign rsp_active = res_head.active;
   assign rsp_last   = res_head.last;

endmodule

FILE: design/dtmf_checker.sv
// Port-level checks of the DTMF tone generator, bound to its top level.
module dtmf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic [dtmf_pkg::SAMPLE_BITS-1:0]    rsp_sample,
   input logic                                rsp_active,
   input logic                                rsp_last
);

   // Both queues are empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // An idle tick gives a silent result that is never a final sample.
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_active) |-> (rsp_sample == '0) && !rsp_last)
      else $error("idle result carries a sample or last flag");

   a_last_active: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last) |-> rsp_active)
      else $error("last flag on an inactive result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_sample)
                                   && $stable(rsp_active) && $stable(rsp_last))
      else $error("waiting result changed");

endmodule

bind dtmf_tone_generator_with_fade_top dtmf_checker u_checker (.*);
